@@ src/pctd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pctd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_TEST,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic next_div;
        logic emit;
        logic emit_prime;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic below_two;
        logic sq_gt;
        logic div_last;
        logic rem_zero;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

@@ src/pctd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pctd_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire pctd_pkg::stat_t stat,
    output pctd_pkg::cmd_t      cmd
);
    import pctd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   prime_reg;
    logic   prime_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            prime_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prime_reg <= prime_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        prime_next = prime_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.below_two)
                begin
                    prime_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (stat.sq_gt)
                begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_last)
                    state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (stat.rem_zero)
                begin
                    prime_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                    state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.emit_prime = prime_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CHECK:
                cmd.div_start = !stat.below_two && !stat.sq_gt;
            ST_DIV:
                cmd.div_step = 1'b1;
            ST_TEST:
                cmd.next_div = !stat.rem_zero;
            ST_FINISH:
                cmd.emit = stat.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/pctd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pctd_dp #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pctd_pkg::cmd_t         cmd,
    output pctd_pkg::stat_t             stat,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire logic                   last,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        prime,
    output logic [COUNT_WIDTH-1:0]      count,
    output logic                        end_of_list
);
    import pctd_pkg::*;

    localparam int DW = VALUE_WIDTH / 2 + 1;   // trial divisor width
    localparam int SW = VALUE_WIDTH + 1;       // divisor squared width
    localparam int BW = $clog2(VALUE_WIDTH);
    localparam logic [BW-1:0] BIT_TOP = BW'(VALUE_WIDTH - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [VALUE_WIDTH-1:0] val_reg;
    logic                   small_reg;
    logic                   last_reg;
    logic [DW-1:0]          d_reg;
    logic [SW-1:0]          sq_reg;
    logic [VALUE_WIDTH-1:0] vs_reg;
    logic [DW:0]            rem_reg;
    logic [BW-1:0]          bit_reg;
    logic [COUNT_WIDTH-1:0] run_reg;
    logic                   ov_reg;
    logic                   prime_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic                   eol_reg;

    logic [DW:0]            rem_sh;
    logic [DW:0]            rem_next;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic                   val_small;

    assign val_small = value[VALUE_WIDTH-1] || (value < VALUE_WIDTH'(2));

    // one restoring step of value mod d, MSB first
    assign rem_sh   = {rem_reg[DW-1:0], vs_reg[VALUE_WIDTH-1]};
    assign rem_next = (rem_sh >= {1'b0, d_reg}) ? rem_sh - {1'b0, d_reg} : rem_sh;

    assign cnt_next = (cmd.emit_prime && run_reg != CNT_MAX) ? run_reg + 1'b1 : run_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg   <= value;
            small_reg <= val_small;
            last_reg  <= last;
            d_reg     <= DW'(2);
            sq_reg    <= SW'(4);
        end
        if (cmd.next_div)
        begin
            d_reg  <= d_reg + 1'b1;
            sq_reg <= sq_reg + SW'({d_reg, 1'b1});
        end
        if (cmd.div_start)
        begin
            vs_reg  <= val_reg;
            rem_reg <= '0;
            bit_reg <= BIT_TOP;
        end
        else if (cmd.div_step)
        begin
            vs_reg  <= {vs_reg[VALUE_WIDTH-2:0], 1'b0};
            rem_reg <= rem_next;
            bit_reg <= bit_reg - 1'b1;
        end
        if (cmd.emit)
        begin
            prime_reg <= cmd.emit_prime;
            cnt_reg   <= cnt_next;
            eol_reg   <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                run_reg <= last_reg ? '0 : cnt_next;
                ov_reg  <= 1'b1;
            end
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stat           = '0;
        stat.below_two = small_reg;
        stat.sq_gt     = sq_reg > SW'(val_reg);
        stat.div_last  = (bit_reg == '0);
        stat.rem_zero  = (rem_reg == '0);
        stat.out_free  = !ov_reg || out_ready;
    end

    assign out_valid   = ov_reg;
    assign prime       = prime_reg;
    assign count       = cnt_reg;
    assign end_of_list = eol_reg;

endmodule

`default_nettype wire

@@ src/prime_counter_trial_division.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Prime counter by trial division. Each input beat carries a signed value and a
// last flag; each output beat gives the prime flag, the saturating count of primes
// in the current list so far, and end_of_list (then count is the list total).
// One item is worked at a time, through a shared remainder unit that takes one
// bit per cycle. Values below 2, 2 and 3 are decided at the first check;
// otherwise each trial divisor d goes through a check of d*d, VALUE_WIDTH
// remainder steps and a test, and up to about 46340 divisors are tried for
// 32-bit primes. A new item is taken while the previous result waits in the
// output register.
module prime_counter_trial_division #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire logic                   last,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        prime,
    output logic [COUNT_WIDTH-1:0]      count,
    output logic                        end_of_list
);
    import pctd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pctd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pctd_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .prime       (prime),
        .count       (count),
        .end_of_list (end_of_list)
    );

    // busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous item still in progress");

    // a prime result always counts at least itself
    a_prime_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && prime |-> count != '0)
        else $error("prime result with zero count");

    // division only starts for candidates that still need a divisor tried
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.below_two && !stat.sq_gt)
        else $error("remainder step started for a decided value");

    // emit only when the output slot can take the result
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result emitted over a pending output beat");

endmodule

`default_nettype wire

@@ test/prime_counter_trial_division_test.sv @@
`timescale 1ns / 1ps

module prime_counter_trial_division_test;

    localparam int VW = 32;
    localparam int CW = 16;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct {
        logic [VW-1:0] number;
        logic          is_last;
        logic          drain_first;
    } list_entry_t;

    typedef struct {
        logic          prime;
        logic [CW-1:0] count;
        logic          eol;
    } verdict_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [VW-1:0] value = '0;
    logic          last = 1'b0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic          prime;
    logic [CW-1:0] count;
    logic          end_of_list;

    list_entry_t   pending_items[$];
    verdict_t      expected_verdicts[$];
    verdict_t      oldest;
    logic          accepted_prime;
    logic [CW-1:0] primes_in_list = '0;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    int unsigned   mismatches = 0;
    int unsigned   quiet_cycles = 0;

    prime_counter_trial_division #(
        .VALUE_WIDTH(VW),
        .COUNT_WIDTH(CW)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .prime      (prime),
        .count      (count),
        .end_of_list(end_of_list)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic value_is_prime(logic [VW-1:0] v);
        longint unsigned n;
        longint unsigned d;
        if (v[VW-1])
            return 1'b0;
        n = v;
        if (n < 2)
            return 1'b0;
        for (d = 2; d * d <= n; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic queue_number(input logic [VW-1:0] n, input logic l, input logic hold);
        list_entry_t e;
        e.number = n;
        e.is_last = l;
        e.drain_first = hold;
        pending_items.push_back(e);
    endtask

    // Mostly small values so trial division stays short; large positives
    // are built with a small factor so they exit after a few divisors.
    task automatic add_random_items(input int n);
        int unsigned   pick;
        int unsigned   p;
        logic [VW-1:0] v;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                v = $urandom_range(300);
            else if (pick < 72)
                v = $urandom_range(20000);
            else if (pick < 77)
                v = $urandom_range(1 << 20);
            else if (pick < 88)
                v = $urandom | 32'h8000_0000;
            else
            begin
                p = $urandom_range(7, 2);
                v = (($urandom & 32'h7fff_ffff) / p) * p;
                if (v < 4 * p)
                    v = 4 * p;
            end
            queue_number(v, $urandom_range(5) == 0, 1'b0);
        end
    endtask

    task automatic wait_until_drained();
        while (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(negedge clk);
    endtask

    // driver: predicts on each accepted beat, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value <= '0;
            last <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                accepted_prime = value_is_prime(value);
                if (accepted_prime && primes_in_list != '1)
                    primes_in_list = primes_in_list + 1'b1;
                expected_verdicts.push_back('{accepted_prime, primes_in_list, last});
                if (last)
                    primes_in_list = '0;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0
                    && !(pending_items[0].drain_first && expected_verdicts.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    value <= pending_items[0].number;
                    last <= pending_items[0].is_last;
                    pending_items.delete(0);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with none expected: prime %0b count %0d eol %0b",
                             $time, prime, count, end_of_list);
                end
                else
                begin
                    oldest = expected_verdicts[0];
                    expected_verdicts.delete(0);
                    if (prime !== oldest.prime || count !== oldest.count
                        || end_of_list !== oldest.eol)
                    begin
                        mismatches++;
                        if (prime !== oldest.prime)
                            $display("%0t: prime expected %0b actual %0b",
                                     $time, oldest.prime, prime);
                        if (count !== oldest.count)
                            $display("%0t: count expected %0d actual %0d",
                                     $time, oldest.count, count);
                        if (end_of_list !== oldest.eol)
                            $display("%0t: end_of_list expected %0b actual %0b",
                                     $time, oldest.eol, end_of_list);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL prime_counter_trial_division");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 38;
        recv_idle_pct = 75;
        // below two, then a single-item list
        queue_number(32'h8000_0000, 1'b0, 1'b0);
        queue_number(32'hffff_ffff, 1'b0, 1'b0);
        queue_number(32'd0, 1'b0, 1'b0);
        queue_number(32'd1, 1'b1, 1'b0);
        queue_number(32'd2, 1'b1, 1'b0);
        // squares of primes sit right on the d*d <= n bound
        queue_number(32'd3, 1'b0, 1'b0);
        queue_number(32'd4, 1'b0, 1'b0);
        queue_number(32'd9, 1'b0, 1'b0);
        queue_number(32'd25, 1'b0, 1'b0);
        queue_number(32'd49, 1'b0, 1'b0);
        queue_number(32'd121, 1'b0, 1'b0);
        queue_number(32'd97, 1'b1, 1'b0);
        queue_number(32'd7919, 1'b0, 1'b0);
        queue_number(32'd65521, 1'b0, 1'b0);
        queue_number(32'd1018081, 1'b0, 1'b0);
        queue_number(32'h7fff_fffe, 1'b0, 1'b0);
        queue_number(32'h7fff_fffd, 1'b1, 1'b0);
        queue_number(32'd2, 1'b1, 1'b0);
        queue_number(32'd3, 1'b1, 1'b0);
        add_random_items(25);
        wait_until_drained();

        send_idle_pct = 75;
        recv_idle_pct = 38;
        add_random_items(15);
        // sender holds until everything in flight has come back
        queue_number(32'd65537, 1'b1, 1'b1);
        add_random_items(20);
        wait_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_items(20);
        queue_number(32'd5, 1'b0, 1'b0);
        queue_number(32'd8, 1'b1, 1'b0);
        wait_until_drained();

        repeat (50) @(negedge clk);
        if (expected_verdicts.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_verdicts.size());
        end
        if (mismatches == 0)
            $display("PASS prime_counter_trial_division");
        else
            $display("FAIL prime_counter_trial_division");
        $finish;
    end

endmodule
